// ===== hdl/ffsa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ffsa_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EXHAUSTED = 2'd1,
    STATUS_BEYOND    = 2'd2,
    STATUS_FULL      = 2'd3
  } status_t;

  // One datapath action per cycle, chosen by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_BEYOND,
    OP_SCAN,
    OP_TRIM,
    OP_HIT_DROP,
    OP_GROW,
    OP_MERGE_B,
    OP_MERGE_A,
    OP_MERGE_AO,
    OP_WR_BEFORE,
    OP_WR_AFTER,
    OP_APPEND,
    OP_DROP,
    OP_RESP
  } dp_op_t;

  // Address source for the span memory read port.
  typedef enum logic [1:0] {
    RD_ZERO,
    RD_NEXT,
    RD_LAST
  } rd_sel_t;

  typedef struct packed {
    dp_op_t  op;
    rd_sel_t rd_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic beyond;
    logic list_empty;
    logic scan_last;
    logic fit;
    logic exact;
    logic have_before;
    logic have_after;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/ffsa_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ffsa_ctrl
  import ffsa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_tvalid,
  output logic          s_tready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_DECIDE,
    S_MERGE_A,
    S_WR_BEFORE,
    S_WR_AFTER,
    S_DROP_RD,
    S_DROP_WR,
    S_RESP
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.rd_sel = RD_NEXT;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.op     = OP_LOAD;
          state_next = S_START;
        end
      end
      S_START: begin
        cmd.rd_sel = RD_ZERO;
        if (stat.is_free && stat.beyond) begin
          cmd.op     = OP_BEYOND;
          state_next = S_RESP;
        end else if (stat.list_empty) begin
          state_next = S_DECIDE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!stat.is_free && stat.fit) begin
          if (stat.exact) begin
            cmd.op     = OP_HIT_DROP;
            state_next = S_DROP_RD;
          end else begin
            cmd.op     = OP_TRIM;
            state_next = S_RESP;
          end
        end else begin
          cmd.op = OP_SCAN;
          if (stat.scan_last) begin
            state_next = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        if (!stat.is_free) begin
          cmd.op     = OP_GROW;
          state_next = S_RESP;
        end else if (stat.have_before) begin
          cmd.op     = OP_MERGE_B;
          state_next = stat.have_after ? S_MERGE_A : S_WR_BEFORE;
        end else if (stat.have_after) begin
          cmd.op     = OP_MERGE_AO;
          state_next = S_WR_AFTER;
        end else begin
          cmd.op     = OP_APPEND;
          state_next = S_RESP;
        end
      end
      S_MERGE_A: begin
        cmd.op     = OP_MERGE_A;
        state_next = S_WR_BEFORE;
      end
      S_WR_BEFORE: begin
        cmd.op     = OP_WR_BEFORE;
        state_next = stat.have_after ? S_DROP_RD : S_RESP;
      end
      S_WR_AFTER: begin
        cmd.op     = OP_WR_AFTER;
        state_next = S_RESP;
      end
      S_DROP_RD: begin
        cmd.rd_sel = RD_LAST;
        state_next = S_DROP_WR;
      end
      S_DROP_WR: begin
        cmd.op     = OP_DROP;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.op     = OP_RESP;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ffsa_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ffsa_dp
  import ffsa_pkg::*;
#(
  parameter int MAX_FREE_SPANS = 64,
  parameter int OFFSET_WIDTH   = 24
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_type,
  input  wire logic [OFFSET_WIDTH-1:0] in_size,
  input  wire logic [OFFSET_WIDTH-1:0] in_base,
  input  wire dp_cmd_t                 cmd,
  output dp_stat_t                     stat,
  input  wire logic                    m_tready,
  output logic                         m_tvalid,
  output logic [OFFSET_WIDTH-1:0]      out_offset,
  output logic [1:0]                   out_status
);

  localparam int OW    = OFFSET_WIDTH;
  localparam int IDX_W = (MAX_FREE_SPANS > 1) ? $clog2(MAX_FREE_SPANS) : 1;
  localparam int CNT_W = $clog2(MAX_FREE_SPANS + 1);

  function automatic logic [OW-1:0] sat_add(input logic [OW-1:0] a, input logic [OW-1:0] b);
    logic [OW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[OW] ? {OW{1'b1}} : s[OW-1:0];
  endfunction

  // Span memory, one read and one write port, registered read data.
  logic [OW-1:0] mem_start [MAX_FREE_SPANS];
  logic [OW-1:0] mem_len   [MAX_FREE_SPANS];
  logic [OW-1:0] rd_start;
  logic [OW-1:0] rd_len;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [OW-1:0]    wr_start;
  logic [OW-1:0]    wr_len;

  // Request and bookkeeping.
  logic             req_free;
  logic [OW-1:0]    req_size;
  logic [OW-1:0]    req_base;
  logic [OW:0]      req_end;
  logic [OW:0]      high_water;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] scan_idx;
  logic             have_before;
  logic             have_after;
  logic [IDX_W-1:0] before_idx;
  logic [IDX_W-1:0] after_idx;
  logic [IDX_W-1:0] drop_idx;
  logic [OW-1:0]    before_start;
  logic [OW-1:0]    before_len;
  logic [OW-1:0]    after_len;
  logic [OW-1:0]    merge_len;
  logic [OW-1:0]    res_offset;
  status_t          res_status;

  logic [CNT_W-1:0] scan_next;
  logic [CNT_W-1:0] count_m1;
  logic             list_full;
  logic [OW:0]      grow_sum;
  logic             exhausted;
  logic             end_match;
  logic             before_match;
  logic [OW-1:0]    merge_a;
  logic [OW-1:0]    merge_b;
  logic [OW-1:0]    merge_sum;

  assign scan_next = scan_idx + CNT_W'(1);
  assign count_m1  = count - CNT_W'(1);
  assign list_full = (count == CNT_W'(MAX_FREE_SPANS));
  assign grow_sum  = high_water + {1'b0, req_size};
  assign exhausted = high_water[OW] || (grow_sum > ((OW+1)'(1) << OW));
  assign end_match    = ({1'b0, rd_start} == req_end);
  assign before_match = (({1'b0, rd_start} + {1'b0, rd_len}) == {1'b0, req_base});

  always_comb begin
    case (cmd.op)
      OP_MERGE_A:  begin merge_a = merge_len;  merge_b = after_len; end
      OP_MERGE_AO: begin merge_a = after_len;  merge_b = req_size;  end
      default:     begin merge_a = before_len; merge_b = req_size;  end
    endcase
  end
  assign merge_sum = sat_add(merge_a, merge_b);

  always_comb begin
    case (cmd.rd_sel)
      RD_ZERO: rd_addr = '0;
      RD_NEXT: rd_addr = scan_next[IDX_W-1:0];
      RD_LAST: rd_addr = count_m1[IDX_W-1:0];
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = drop_idx;
    wr_start = rd_start;
    wr_len   = rd_len;
    case (cmd.op)
      OP_TRIM: begin
        wr_en    = 1'b1;
        wr_addr  = scan_idx[IDX_W-1:0];
        wr_start = rd_start + req_size;
        wr_len   = rd_len - req_size;
      end
      OP_WR_BEFORE: begin
        wr_en    = 1'b1;
        wr_addr  = before_idx;
        wr_start = before_start;
        wr_len   = merge_len;
      end
      OP_WR_AFTER: begin
        wr_en    = 1'b1;
        wr_addr  = after_idx;
        wr_start = req_base;
        wr_len   = merge_len;
      end
      OP_APPEND: begin
        wr_en    = !list_full;
        wr_addr  = count[IDX_W-1:0];
        wr_start = req_base;
        wr_len   = req_size;
      end
      OP_DROP: begin
        wr_en = 1'b1;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_start[wr_addr] <= wr_start;
      mem_len[wr_addr]   <= wr_len;
    end
    rd_start <= mem_start[rd_addr];
    rd_len   <= mem_len[rd_addr];
  end

  // Control state: list fill, high-water mark, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      high_water <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cmd.op == OP_RESP) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (cmd.op)
        OP_GROW: begin
          if (!exhausted) begin
            high_water <= grow_sum;
          end
        end
        OP_APPEND: begin
          if (!list_full) begin
            count <= count + CNT_W'(1);
          end
        end
        OP_DROP: begin
          count <= count_m1;
        end
        default: begin
        end
      endcase
    end
  end

  // Per-request working registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        req_free    <= in_type;
        req_size    <= in_size;
        req_base    <= in_base;
        req_end     <= {1'b0, in_base} + {1'b0, in_size};
        scan_idx    <= '0;
        have_before <= 1'b0;
        have_after  <= 1'b0;
        res_offset  <= '0;
        res_status  <= STATUS_OK;
      end
      OP_BEYOND: begin
        res_status <= STATUS_BEYOND;
      end
      OP_SCAN: begin
        scan_idx <= scan_next;
        if (req_free) begin
          if (end_match) begin
            have_after <= 1'b1;
            after_idx  <= scan_idx[IDX_W-1:0];
            after_len  <= rd_len;
          end
          if (before_match) begin
            have_before  <= 1'b1;
            before_idx   <= scan_idx[IDX_W-1:0];
            before_start <= rd_start;
            before_len   <= rd_len;
          end
        end
      end
      OP_TRIM: begin
        res_offset <= rd_start;
      end
      OP_HIT_DROP: begin
        res_offset <= rd_start;
        drop_idx   <= scan_idx[IDX_W-1:0];
      end
      OP_GROW: begin
        if (exhausted) begin
          res_status <= STATUS_EXHAUSTED;
        end else begin
          res_offset <= high_water[OW-1:0];
        end
      end
      OP_MERGE_B, OP_MERGE_A, OP_MERGE_AO: begin
        merge_len <= merge_sum;
      end
      OP_WR_BEFORE: begin
        drop_idx <= after_idx;
      end
      OP_APPEND: begin
        if (list_full) begin
          res_status <= STATUS_FULL;
        end
      end
      OP_RESP: begin
        out_offset <= res_offset;
        out_status <= res_status;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat.is_free     = req_free;
    stat.beyond      = (req_end > high_water);
    stat.list_empty  = (count == '0);
    stat.scan_last   = (scan_next == count);
    stat.fit         = (rd_len >= req_size);
    stat.exact       = (rd_len == req_size);
    stat.have_before = have_before;
    stat.have_after  = have_after;
    stat.out_free    = !m_tvalid || m_tready;
  end

endmodule

`default_nettype wire

// ===== hdl/first_fit_span_allocator_top.sv =====
// First-fit span allocator over a linear offset space of 2^OFFSET_WIDTH units.
// Each transaction on the slave stream is one request: an allocate (s_tuser low)
// takes the first listed free span that is long enough, trimming it from the
// front or, when it fits exactly, removing it by moving the last list entry into
// its slot; if no span fits, the grant comes from the high-water mark, which then
// grows. A free (s_tuser high) merges the span with a listed neighbor that ends
// at its start and/or one that starts at its end (the highest-indexed match
// wins), or appends it to the list. Exactly one result transaction follows each
// request, carrying the granted offset (zero for frees and failures) and a
// status: 0 ok, 1 address space exhausted, 2 free beyond the high-water mark,
// 3 free list full; a failed request changes nothing. Requests are handled one
// at a time. The free list lives in a span memory with one read and one write
// port that is walked one entry per cycle. A request is finished only once the
// result slot is free, and a new request is taken while the previous result
// still waits on the master stream. No clearing pass is needed after reset:
// only list entries below the fill count are ever used.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_span_allocator_top
  import ffsa_pkg::*;
#(
  parameter int MAX_FREE_SPANS = 64,
  parameter int OFFSET_WIDTH   = 24
) (
  input  wire logic clk,
  input  wire logic rst,
  // Request stream.
  input  wire logic s_tvalid,
  output logic      s_tready,
  // Fields from bit 0: span_size, base_offset, zero padding.
  input  wire logic [((2*OFFSET_WIDTH+7)/8)*8-1:0] s_tdata,
  // Fields from bit 0: req_type.
  input  wire logic [0:0] s_tuser,
  // Result stream.
  output logic      m_tvalid,
  input  wire logic m_tready,
  // Fields from bit 0: alloc_offset, status, zero padding.
  output logic [((OFFSET_WIDTH+2+7)/8)*8-1:0] m_tdata
);

  localparam int M_W = ((OFFSET_WIDTH+2+7)/8)*8;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic [OFFSET_WIDTH-1:0] out_offset;
  logic [1:0]              out_status;

  // The controller walks each request through scan, merge and update steps;
  // the datapath owns the span memory, the fill count and the high-water mark.
  ffsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ffsa_dp #(
    .MAX_FREE_SPANS (MAX_FREE_SPANS),
    .OFFSET_WIDTH   (OFFSET_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_type    (s_tuser[0]),
    .in_size    (s_tdata[OFFSET_WIDTH-1:0]),
    .in_base    (s_tdata[2*OFFSET_WIDTH-1:OFFSET_WIDTH]),
    .cmd        (cmd),
    .stat       (stat),
    .m_tready   (m_tready),
    .m_tvalid   (m_tvalid),
    .out_offset (out_offset),
    .out_status (out_status)
  );

  assign m_tdata = M_W'({out_status, out_offset});

endmodule

`default_nettype wire
